[rtl/core/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// Shared types, codes and constants of the active cell linked set.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int MAX_CELLS_DEF = 4096;
  localparam int COORD_W       = 8;
  localparam int CFG_W         = 9;
  localparam int COUNT_W       = 13;
  localparam int PLANE_W       = 2 * CFG_W;            // columns * rows
  localparam int PROD_K_W      = COORD_W + PLANE_W;    // k * plane
  localparam int PROD_I_W      = COORD_W + CFG_W;      // i * columns
  localparam int IDX_W         = PROD_K_W + 1;         // full slot sum
  localparam int INFO_W        = 1 + 3 * COORD_W;      // active + coords
  localparam int CFG_AW        = 4;
  localparam int CFG_DW        = 32;

  localparam logic [CFG_W-1:0] GRID_DIM_RST = 9'd16;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_SLICES  = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NOCHG   = 2'd1;
  localparam logic [1:0] STAT_OUTSIDE = 2'd2;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIRST  = 3'd2,
    OP_NEXT   = 3'd3,
    OP_END    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_READ,
    ST_FETCH
  } state_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [COORD_W-1:0] cell_i;
    logic [COORD_W-1:0] cell_j;
    logic [COORD_W-1:0] cell_k;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [COORD_W-1:0] out_i;
    logic [COORD_W-1:0] out_j;
    logic [COORD_W-1:0] out_k;
    logic [COUNT_W-1:0] active_count;
  } out_t;

endpackage

[rtl/core/active_cell_linked_set.sv]
// ----------------------------------------------------------------------------
// active_cell_linked_set
// Set of active cells of a 3D grid, kept as a doubly linked list of slots.
// ----------------------------------------------------------------------------
// Input beats carry an operation (add, remove, first, next, end iteration)
// and a cell's i/j/k. Each input beat gives exactly one result beat with a
// status, a found flag, the returned cell and the active count after it.
// Grid sizes are set through the APB port and must be changed only while idle;
// the block itself does not enforce this. The input stalls in the cycle after a
// register write while the plane size settles.
// An accepted item passes through ST_INDEX, which forms the slot-index sum and
// issues the slot memory read, and ST_READ, the commit step that writes the
// neighbor links back and loads the result register; a next that returns a cell
// adds ST_FETCH, a second read of the successor's coordinates. Items are handled
// one at a time: no new item is accepted before the current one commits.
// After reset the block clears the active bits of all MAX_CELLS slots, one
// slot a cycle, and holds in_stall high until the clearing pass is done.
// A finished result waits in the output register while out_stall is high;
// the next item is already accepted, and its commit waits for that register.
// ----------------------------------------------------------------------------
module active_cell_linked_set #(
  parameter int MAX_CELLS = acs_pkg::MAX_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  acs_pkg::in_t                in_data,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output acs_pkg::out_t               out_data,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acs_pkg::CFG_AW-1:0]  paddr,
  input  logic [acs_pkg::CFG_DW-1:0]  pwdata,
  output logic [acs_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int AW = $clog2(MAX_CELLS);
  localparam int LW = $clog2(MAX_CELLS + 1);
  localparam logic [LW-1:0] Nil     = LW'(MAX_CELLS);
  localparam logic [AW-1:0] LastSlot = AW'(MAX_CELLS - 1);

  localparam int CW = acs_pkg::COORD_W;

  // configuration registers
  logic [acs_pkg::CFG_W-1:0]   cols_r, rows_r, slices_r;
  logic [acs_pkg::PLANE_W-1:0] plane_r;
  logic                        cfg_we;
  logic                        cfg_hold_r;

  // control
  acs_pkg::state_t           state_r, state_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [LW-1:0]             head_r, head_nxt;
  logic [LW-1:0]             tail_r, tail_nxt;
  logic [LW-1:0]             bnd_r, bnd_nxt;
  logic [LW-1:0]             cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // item payload
  logic [2:0]                  op_r, op_nxt;
  logic [CW-1:0]               ci_r, ci_nxt, cj_r, cj_nxt, ck_r, ck_nxt;
  logic                        bad_r, bad_nxt;
  logic [acs_pkg::PROD_K_W-1:0] pk_r, pk_nxt;
  logic [acs_pkg::PROD_I_W-1:0] pi_r, pi_nxt;
  logic [AW-1:0]               slot_r, slot_nxt;
  logic                        slot_bad_r, slot_bad_nxt;
  logic [AW-1:0]               rd_addr_r, rd_addr;
  acs_pkg::out_t               out_data_r, out_data_nxt;

  logic [acs_pkg::IDX_W-1:0]   idx_sum;

  // memories
  logic                        info_we, next_we, prev_we;
  logic [AW-1:0]               info_waddr, next_waddr, prev_waddr;
  logic [acs_pkg::INFO_W-1:0]  info_wdata, info_rd;
  logic [LW-1:0]               next_wdata, prev_wdata, next_rd, prev_rd;

  // decode helpers in the read cycle
  logic [LW-1:0]               s_link, n_link, p_link;
  logic                        act, out_free;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= acs_pkg::GRID_DIM_RST;
      rows_r   <= acs_pkg::GRID_DIM_RST;
      slices_r <= acs_pkg::GRID_DIM_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        acs_pkg::REG_COLUMNS: cols_r   <= pwdata[acs_pkg::CFG_W-1:0];
        acs_pkg::REG_ROWS:    rows_r   <= pwdata[acs_pkg::CFG_W-1:0];
        acs_pkg::REG_SLICES:  slices_r <= pwdata[acs_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      acs_pkg::REG_COLUMNS: prdata = acs_pkg::CFG_DW'(cols_r);
      acs_pkg::REG_ROWS:    prdata = acs_pkg::CFG_DW'(rows_r);
      acs_pkg::REG_SLICES:  prdata = acs_pkg::CFG_DW'(slices_r);
      default:              prdata = '0;
    endcase
  end

  // plane size follows the registers in the cycle after; hold the input meanwhile
  always_ff @(posedge clk) begin
    plane_r    <= acs_pkg::PLANE_W'(cols_r) * acs_pkg::PLANE_W'(rows_r);
    cfg_hold_r <= cfg_we;
  end

  // --------------------------------------------------------------------------
  // Slot memories: active bit + coords, next links, prev links
  // --------------------------------------------------------------------------
  acs_ram #(.WIDTH(acs_pkg::INFO_W), .DEPTH(MAX_CELLS)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (rd_addr),
    .rdata (info_rd)
  );

  acs_ram #(.WIDTH(LW), .DEPTH(MAX_CELLS)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (next_rd)
  );

  acs_ram #(.WIDTH(LW), .DEPTH(MAX_CELLS)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (prev_rd)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign idx_sum  = acs_pkg::IDX_W'(pk_r) + acs_pkg::IDX_W'(pi_r) + acs_pkg::IDX_W'(cj_r);
  assign s_link   = LW'(slot_r);
  assign act      = info_rd[acs_pkg::INFO_W-1];
  // the next link of a newly appended tail is not written: treat the tail as the end
  assign n_link   = (s_link == tail_r) ? Nil : next_rd;
  assign p_link   = prev_rd;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    bnd_nxt       = bnd_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    ck_nxt        = ck_r;
    bad_nxt       = bad_r;
    pk_nxt        = pk_r;
    pi_nxt        = pi_r;
    slot_nxt      = slot_r;
    slot_bad_nxt  = slot_bad_r;
    rd_addr       = rd_addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    in_stall      = 1'b1;
    info_we       = 1'b0;
    info_waddr    = slot_r;
    info_wdata    = '0;
    next_we       = 1'b0;
    next_waddr    = tail_r[AW-1:0];
    next_wdata    = s_link;
    prev_we       = 1'b0;
    prev_waddr    = slot_r;
    prev_wdata    = tail_r;

    case (state_r)
      acs_pkg::ST_CLEAR: begin
        info_we    = 1'b1;
        info_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == LastSlot) begin
          state_nxt = acs_pkg::ST_IDLE;
        end
      end

      acs_pkg::ST_IDLE: begin
        in_stall = cfg_hold_r;
        if (in_valid && !cfg_hold_r) begin
          op_nxt    = in_data.operation;
          ci_nxt    = in_data.cell_i;
          cj_nxt    = in_data.cell_j;
          ck_nxt    = in_data.cell_k;
          bad_nxt   = ({1'b0, in_data.cell_i} >= rows_r) ||
                      ({1'b0, in_data.cell_j} >= cols_r) ||
                      ({1'b0, in_data.cell_k} >= slices_r);
          pk_nxt    = acs_pkg::PROD_K_W'(in_data.cell_k) * acs_pkg::PROD_K_W'(plane_r);
          pi_nxt    = acs_pkg::PROD_I_W'(in_data.cell_i) * acs_pkg::PROD_I_W'(cols_r);
          state_nxt = acs_pkg::ST_INDEX;
        end
      end

      acs_pkg::ST_INDEX: begin
        slot_nxt     = idx_sum[AW-1:0];
        slot_bad_nxt = bad_r || (idx_sum >= acs_pkg::IDX_W'(MAX_CELLS));
        rd_addr      = (op_r == acs_pkg::OP_FIRST) ? head_r[AW-1:0] : idx_sum[AW-1:0];
        state_nxt    = acs_pkg::ST_READ;
      end

      acs_pkg::ST_READ: begin
        if (op_r == acs_pkg::OP_NEXT && !slot_bad_r && act &&
            n_link != Nil && n_link != bnd_r) begin
          // fetch the successor's coordinates
          rd_addr   = n_link[AW-1:0];
          state_nxt = acs_pkg::ST_FETCH;
        end else if (out_free) begin
          out_data_nxt        = '0;
          out_data_nxt.status = acs_pkg::STAT_DONE;
          case (op_r)
            acs_pkg::OP_ADD: begin
              if (slot_bad_r) begin
                out_data_nxt.status = acs_pkg::STAT_OUTSIDE;
              end else if (act) begin
                out_data_nxt.status = acs_pkg::STAT_NOCHG;
              end else begin
                info_we    = 1'b1;
                info_wdata = {1'b1, ck_r, cj_r, ci_r};
                prev_we    = 1'b1;
                next_we    = (tail_r != Nil);
                if (tail_r == Nil) begin
                  head_nxt = s_link;
                end
                tail_nxt = s_link;
                if (bnd_r == Nil) begin
                  bnd_nxt = s_link;
                end
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            acs_pkg::OP_REMOVE: begin
              if (slot_bad_r) begin
                out_data_nxt.status = acs_pkg::STAT_OUTSIDE;
              end else if (!act) begin
                out_data_nxt.status = acs_pkg::STAT_NOCHG;
              end else begin
                info_we    = 1'b1;
                next_we    = (p_link != Nil);
                next_waddr = p_link[AW-1:0];
                next_wdata = n_link;
                prev_we    = (n_link != Nil);
                prev_waddr = n_link[AW-1:0];
                prev_wdata = p_link;
                if (p_link == Nil) begin
                  head_nxt = n_link;
                end
                if (n_link == Nil) begin
                  tail_nxt = p_link;
                end
                if (bnd_r == s_link) begin
                  bnd_nxt = n_link;
                end
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            acs_pkg::OP_FIRST: begin
              if (head_r != Nil) begin
                out_data_nxt.found = 1'b1;
                out_data_nxt.out_i = info_rd[CW-1:0];
                out_data_nxt.out_j = info_rd[2*CW-1:CW];
                out_data_nxt.out_k = info_rd[3*CW-1:2*CW];
              end
            end
            acs_pkg::OP_NEXT: begin
              if (slot_bad_r) begin
                out_data_nxt.status = acs_pkg::STAT_OUTSIDE;
              end
            end
            acs_pkg::OP_END: begin
              bnd_nxt = Nil;
            end
            default: ;
          endcase
          out_data_nxt.active_count = acs_pkg::COUNT_W'(cnt_nxt);
          out_valid_nxt             = 1'b1;
          state_nxt                 = acs_pkg::ST_IDLE;
        end
      end

      acs_pkg::ST_FETCH: begin
        if (out_free) begin
          out_data_nxt              = '0;
          out_data_nxt.status       = acs_pkg::STAT_DONE;
          out_data_nxt.found        = 1'b1;
          out_data_nxt.out_i        = info_rd[CW-1:0];
          out_data_nxt.out_j        = info_rd[2*CW-1:CW];
          out_data_nxt.out_k        = info_rd[3*CW-1:2*CW];
          out_data_nxt.active_count = acs_pkg::COUNT_W'(cnt_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = acs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = acs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acs_pkg::ST_CLEAR;
      clr_r       <= '0;
      head_r      <= Nil;
      tail_r      <= Nil;
      bnd_r       <= Nil;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      bnd_r       <= bnd_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    ci_r       <= ci_nxt;
    cj_r       <= cj_nxt;
    ck_r       <= ck_nxt;
    bad_r      <= bad_nxt;
    pk_r       <= pk_nxt;
    pi_r       <= pi_nxt;
    slot_r     <= slot_nxt;
    slot_bad_r <= slot_bad_nxt;
    rd_addr_r  <= rd_addr;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_empty_list : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) == (head_r == Nil))
    else $error("count and head disagree on an empty list");

  a_head_tail : assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == Nil) == (tail_r == Nil))
    else $error("head and tail disagree on an empty list");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an item is in flight");

  a_no_result_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == acs_pkg::ST_CLEAR |-> !out_valid)
    else $error("result beat during clearing pass");

  a_coords_zero : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && !out_data.found |->
      out_data.out_i == '0 && out_data.out_j == '0 && out_data.out_k == '0)
    else $error("coordinates set on a result without a cell");

endmodule

[rtl/core/acs_ram.sv]
// ----------------------------------------------------------------------------
// acs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module acs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
